// ----- hdl/lkv_pkg.sv -----
package lkv_pkg;

    // Number of entries in the store.
    localparam int ENTRIES = 16;

    // Slot index and recency rank width.
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Occupancy count width, wide enough to hold ENTRIES itself.
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Key and value width.
    localparam int DATA_W = 32;

    // Capacity register width and reset value.
    localparam int                 CAP_W     = 5;
    localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;

    // Width used to compare the occupancy count against the capacity.
    localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

    // Result value of a get that misses.
    localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    // Decision for one operation, handed from the lookup to the entry array.
    typedef struct packed {
        logic hit;        // key present: touch the matching slot
        t_idx hit_idx;
        logic insert;     // put of a new key
        logic evict;      // insert replaces the least recent entry
        t_idx ins_idx;    // slot that receives the new key
    } t_decision;

    // Capacity clamped to the range 1 to ENTRIES.
    function automatic logic [CMP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] c;
        c = CMP_W'(cap);
        if (c == '0) begin
            c = CMP_W'(1);
        end
        if (c > CMP_W'(ENTRIES)) begin
            c = CMP_W'(ENTRIES);
        end
        return c;
    endfunction

endpackage

// ----- hdl/lkv_lookup.sv -----
module lkv_lookup (
    input  lkv_pkg::t_op                   i_op,
    input  lkv_pkg::t_data                 i_key,
    input  logic [lkv_pkg::ENTRIES-1:0]    i_valid,
    input  lkv_pkg::t_data                 i_keys [lkv_pkg::ENTRIES],
    input  lkv_pkg::t_idx                  i_rank [lkv_pkg::ENTRIES],
    input  lkv_pkg::t_cnt                  i_count,
    input  logic [lkv_pkg::CAP_W-1:0]      i_capacity,
    output lkv_pkg::t_decision             o_dec
);

    logic [lkv_pkg::ENTRIES-1:0] match;
    logic [lkv_pkg::ENTRIES-1:0] oldest;
    lkv_pkg::t_idx               hit_idx;
    lkv_pkg::t_idx               free_idx;
    lkv_pkg::t_idx               victim_idx;
    lkv_pkg::t_cnt               cnt_m1;
    logic                        hit;
    logic                        full;
    logic                        insert;

    // Valid ranks always form a permutation of 0 to count-1, so the
    // least recent entry is the valid one whose rank is count-1.
    assign cnt_m1 = i_count - lkv_pkg::CNT_W'(1);

    // Parallel key compare and oldest-entry detect.
    always_comb begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            match[i]  = i_valid[i] && (i_keys[i] == i_key);
            oldest[i] = i_valid[i] && (i_rank[i] == cnt_m1[lkv_pkg::IDX_W-1:0]);
        end
    end

    // Encode the matching slot, the lowest free slot and the victim slot.
    always_comb begin
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = lkv_pkg::IDX_W'(i);
            end
            if (!i_valid[i]) begin
                free_idx = lkv_pkg::IDX_W'(i);
            end
            if (oldest[i]) begin
                victim_idx = lkv_pkg::IDX_W'(i);
            end
        end
    end

    assign hit    = |match;
    assign full   = lkv_pkg::CMP_W'(i_count) >= lkv_pkg::eff_capacity(i_capacity);
    assign insert = (i_op == lkv_pkg::OP_PUT) && !hit;

    always_comb begin
        o_dec.hit     = hit;
        o_dec.hit_idx = hit_idx;
        o_dec.insert  = insert;
        o_dec.evict   = insert && full;
        o_dec.ins_idx = (insert && full) ? victim_idx : free_idx;
    end

endmodule

// ----- hdl/lkv_entry_array.sv -----
module lkv_entry_array (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  lkv_pkg::t_op                   i_op,
    input  lkv_pkg::t_data                 i_key,
    input  lkv_pkg::t_data                 i_value,
    input  lkv_pkg::t_decision             i_dec,
    output logic [lkv_pkg::ENTRIES-1:0]    o_valid,
    output lkv_pkg::t_data                 o_keys [lkv_pkg::ENTRIES],
    output lkv_pkg::t_idx                  o_rank [lkv_pkg::ENTRIES],
    output lkv_pkg::t_cnt                  o_count,
    output lkv_pkg::t_data                 o_hit_value
);

    logic [lkv_pkg::ENTRIES-1:0] r_valid;
    lkv_pkg::t_data              r_keys   [lkv_pkg::ENTRIES];
    lkv_pkg::t_data              r_values [lkv_pkg::ENTRIES];
    lkv_pkg::t_idx               r_rank   [lkv_pkg::ENTRIES];
    lkv_pkg::t_cnt               r_count;
    lkv_pkg::t_idx               hit_rank;

    assign hit_rank = r_rank[i_dec.hit_idx];

    // Valid bits, recency ranks and occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '{default: '0};
            r_count <= '0;
        end else if (i_en) begin
            if (i_dec.hit) begin
                // Touch: entries more recent than the hit slot age by one.
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (lkv_pkg::IDX_W'(i) == i_dec.hit_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                        r_rank[i] <= r_rank[i] + lkv_pkg::IDX_W'(1);
                    end
                end
            end else if (i_dec.insert) begin
                // Insert: every other valid entry ages by one.
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (lkv_pkg::IDX_W'(i) == i_dec.ins_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + lkv_pkg::IDX_W'(1);
                    end
                end
                r_valid[i_dec.ins_idx] <= 1'b1;
                if (!i_dec.evict) begin
                    r_count <= r_count + lkv_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Key and value storage; entries are only read once valid.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_dec.hit && (i_op == lkv_pkg::OP_PUT)) begin
                r_values[i_dec.hit_idx] <= i_value;
            end else if (i_dec.insert) begin
                r_keys[i_dec.ins_idx]   <= i_key;
                r_values[i_dec.ins_idx] <= i_value;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_keys      = r_keys;
    assign o_rank      = r_rank;
    assign o_count     = r_count;
    assign o_hit_value = r_values[i_dec.hit_idx];

endmodule

// ----- hdl/lru_key_value_cache_core.sv -----
// Fully associative key/value cache with least-recently-used replacement.
//
// Command channel: an operation is taken at a rising edge with start high
// and busy low. i_opcode selects get or put, i_lookup_key is the key and
// i_write_value the data stored by a put. busy is high only while reset is
// applied and in the cycle after it, so one operation can be taken per cycle.
//
// Result channel: o_result_strobe marks one cycle carrying o_hit,
// o_read_value and o_evicted. An operation passes through the command
// register, then one pass of key compare and recency update into the
// result register. Results keep command order; the receiver cannot stall
// them.
//
// Configuration channel: i_cfg_valid/o_cfg_ready transfer the capacity in
// use (i_cfg_data); write it only while no operation is in flight.
//
// Reset clears every valid bit, the recency ranks and the occupancy count,
// and sets the capacity to 16. No clearing pass is needed.
module lru_key_value_cache_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_opcode,
    input  logic signed [31:0]             i_lookup_key,
    input  logic signed [31:0]             i_write_value,
    output logic                           o_result_strobe,
    output logic                           o_hit,
    output logic signed [31:0]             o_read_value,
    output logic                           o_evicted,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]      i_cfg_data
);

    logic                        r_busy;
    logic [lkv_pkg::CAP_W-1:0]   r_capacity;
    logic                        r_in_vld;
    lkv_pkg::t_op                r_op;
    lkv_pkg::t_data              r_key;
    lkv_pkg::t_data              r_val;
    logic                        r_strobe;
    logic                        r_hit;
    lkv_pkg::t_data              r_read_value;
    logic                        r_evicted;
    lkv_pkg::t_data              n_read_value;

    logic [lkv_pkg::ENTRIES-1:0] valid;
    lkv_pkg::t_data              keys [lkv_pkg::ENTRIES];
    lkv_pkg::t_idx               rank [lkv_pkg::ENTRIES];
    lkv_pkg::t_cnt               count;
    lkv_pkg::t_data              hit_value;
    lkv_pkg::t_decision          dec;
    logic                        accept;

    assign accept = start && !r_busy;

    // Busy only around reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Capacity register, written by a configuration transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkv_pkg::CAP_RESET;
        end else if (i_cfg_valid && !r_busy) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Command register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= lkv_pkg::t_op'(i_opcode);
            r_key <= i_lookup_key;
            r_val <= i_write_value;
        end
    end

    lkv_lookup u_lookup (
        .i_op       (r_op),
        .i_key      (r_key),
        .i_valid    (valid),
        .i_keys     (keys),
        .i_rank     (rank),
        .i_count    (count),
        .i_capacity (r_capacity),
        .o_dec      (dec)
    );

    lkv_entry_array u_entries (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (r_in_vld),
        .i_op        (r_op),
        .i_key       (r_key),
        .i_value     (r_val),
        .i_dec       (dec),
        .o_valid     (valid),
        .o_keys      (keys),
        .o_rank      (rank),
        .o_count     (count),
        .o_hit_value (hit_value)
    );

    // Read data: stored value on a get hit, the miss value on a get miss,
    // zero on a put.
    always_comb begin
        if (r_op == lkv_pkg::OP_PUT) begin
            n_read_value = '0;
        end else if (dec.hit) begin
            n_read_value = hit_value;
        end else begin
            n_read_value = lkv_pkg::MISS_VALUE;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_hit        <= dec.hit;
            r_read_value <= n_read_value;
            r_evicted    <= dec.evict;
        end
    end

    assign busy            = r_busy;
    assign o_cfg_ready     = !r_busy;
    assign o_result_strobe = r_strobe;
    assign o_hit           = r_hit;
    assign o_read_value    = r_read_value;
    assign o_evicted       = r_evicted;

endmodule

// ----- hdl/lkv_checker.sv -----
module lkv_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           i_result_strobe,
    input  logic                           i_hit,
    input  logic signed [31:0]             i_read_value,
    input  logic                           i_evicted
);

    // Every accepted operation yields a result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 i_result_strobe)
        else $error("accepted operation produced no result");

    // No result appears without an operation taken before it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_strobe |-> $past(start && !busy, 2))
        else $error("result without a matching operation");

    // Eviction only happens on a put that missed.
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_strobe && i_evicted) |-> (!i_hit && (i_read_value == 32'sd0)))
        else $error("eviction reported on a hit or on a get");

    // A miss reads either the miss value (get) or zero (put).
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_strobe && !i_hit) |->
            ((i_read_value == -32'sd1) || (i_read_value == 32'sd0)))
        else $error("miss returned stored data");

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_result_strobe (o_result_strobe),
    .i_hit           (o_hit),
    .i_read_value    (o_read_value),
    .i_evicted       (o_evicted)
);

// ----- verif/lru_key_value_cache_core_checker.sv -----
module lru_key_value_cache_core_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_opcode,
    input  logic signed [31:0]            i_lookup_key,
    input  logic signed [31:0]            i_write_value,
    input  logic                          i_result_strobe,
    input  logic                          i_hit,
    input  logic signed [31:0]            i_read_value,
    input  logic                          i_evicted,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    // One lookup answer as it leaves the cache.
    typedef struct packed {
        logic           hit;
        lkv_pkg::t_data read_value;
        logic           evicted;
    } t_reply;

    // Shadow copy of the cache contents and the capacity register.
    lkv_pkg::t_data             slot_key   [lkv_pkg::ENTRIES];
    lkv_pkg::t_data             slot_value [lkv_pkg::ENTRIES];
    logic                       slot_valid [lkv_pkg::ENTRIES];
    lkv_pkg::t_idx              slot_rank  [lkv_pkg::ENTRIES];
    lkv_pkg::t_cnt              fill_count;
    logic [lkv_pkg::CAP_W-1:0]  capacity;

    // Answers still owed by the cache, oldest first.
    t_reply pending_replies[$];
    int     mismatch_total = 0;

    // Make a slot the most recent; valid entries newer than it age by one.
    function automatic void promote_slot(int s);
        lkv_pkg::t_idx old_rank;
        old_rank = slot_rank[s];
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (slot_valid[i] && i != s && slot_rank[i] < old_rank) begin
                slot_rank[i] = slot_rank[i] + 1'b1;
            end
        end
        slot_rank[s] = '0;
    endfunction

    // Apply one get or put to the shadow cache and return its answer.
    function automatic t_reply run_cache_op(lkv_pkg::t_op op, lkv_pkg::t_data key,
                                            lkv_pkg::t_data val);
        t_reply r;
        int     found;
        int     slot;
        int     limit;
        r.hit        = 1'b0;
        r.read_value = '0;
        r.evicted    = 1'b0;
        found        = -1;
        slot         = -1;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (found < 0 && slot_valid[i] && slot_key[i] == key) begin
                found = i;
            end
        end
        r.hit = (found >= 0);

        if (op == lkv_pkg::OP_GET) begin
            if (found >= 0) begin
                r.read_value = slot_value[found];
                promote_slot(found);
            end else begin
                r.read_value = lkv_pkg::MISS_VALUE;
            end
        end else if (found >= 0) begin
            slot_value[found] = val;
            promote_slot(found);
        end else begin
            // Capacity zero behaves as one; anything above the store size saturates.
            limit = int'(capacity);
            if (limit == 0) begin
                limit = 1;
            end
            if (limit > lkv_pkg::ENTRIES) begin
                limit = lkv_pkg::ENTRIES;
            end
            // A full store gives up its oldest entry and reuses that slot.
            if (int'(fill_count) >= limit) begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (slot_valid[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    slot_valid[slot] = 1'b0;
                    r.evicted        = 1'b1;
                end
            end
            // Otherwise the lowest free slot takes the new key.
            if (slot < 0) begin
                for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
                    if (!slot_valid[i]) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    fill_count = fill_count + 1'b1;
                end
            end
            if (slot >= 0) begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (slot_valid[i]) begin
                        slot_rank[i] = slot_rank[i] + 1'b1;
                    end
                end
                slot_key[slot]   = key;
                slot_value[slot] = val;
                slot_valid[slot] = 1'b1;
                slot_rank[slot]  = '0;
            end
        end
        return r;
    endfunction

    function automatic void note_mismatch(string what);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            $display("ERROR: %s", what);
        end
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        t_reply seen;
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_rank[i]  = '0;
            end
            fill_count = '0;
            capacity   = lkv_pkg::CAP_RESET;
            pending_replies.delete();
        end else begin
            // Compare a result transfer with the oldest answer owed.
            if (i_result_strobe) begin
                seen.hit        = i_hit;
                seen.read_value = i_read_value;
                seen.evicted    = i_evicted;
                if (pending_replies.size() == 0) begin
                    note_mismatch($sformatf("result with none expected: hit=%0b value=%0d evicted=%0b",
                                            seen.hit, seen.read_value, seen.evicted));
                end else begin
                    want = pending_replies.pop_front();
                    if (seen.hit !== want.hit || seen.read_value !== want.read_value ||
                        seen.evicted !== want.evicted) begin
                        note_mismatch($sformatf(
                            "expected hit=%0b value=%0d evicted=%0b, got hit=%0b value=%0d evicted=%0b",
                            want.hit, want.read_value, want.evicted,
                            seen.hit, seen.read_value, seen.evicted));
                    end
                end
            end
            // A command transfer yields exactly one answer.
            if (i_start && !i_busy) begin
                pending_replies.push_back(run_cache_op(lkv_pkg::t_op'(i_opcode), i_lookup_key,
                                                       i_write_value));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_cfg_data;
            end
        end
        o_pending    <= pending_replies.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ----- verif/lru_key_value_cache_core_tb.sv -----
module lru_key_value_cache_core_tb;

    localparam int PHASES        = 12;
    localparam int PHASE_OPS     = 125;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 8;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_opcode;
    logic signed [31:0]         i_lookup_key;
    logic signed [31:0]         i_write_value;
    logic                       o_result_strobe;
    logic                       o_hit;
    logic signed [31:0]         o_read_value;
    logic                       o_evicted;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [lkv_pkg::CAP_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    bit gaps_on;

    // Keys of the current phase, so that gets and puts keep hitting the store.
    lkv_pkg::t_data key_pool[$];
    logic [lkv_pkg::CAP_W-1:0] phase_cap[PHASES];

    lru_key_value_cache_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_lookup_key    (i_lookup_key),
        .i_write_value   (i_write_value),
        .o_result_strobe (o_result_strobe),
        .o_hit           (o_hit),
        .o_read_value    (o_read_value),
        .o_evicted       (o_evicted),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    lru_key_value_cache_core_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_opcode        (i_opcode),
        .i_lookup_key    (i_lookup_key),
        .i_write_value   (i_write_value),
        .i_result_strobe (o_result_strobe),
        .i_hit           (o_hit),
        .i_read_value    (o_read_value),
        .i_evicted       (o_evicted),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic lkv_pkg::t_data extreme_word();
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic lkv_pkg::t_data pick_value();
        if ($urandom_range(0, 7) == 0) begin
            return extreme_word();
        end
        return lkv_pkg::t_data'($urandom());
    endfunction

    // Mostly keys from the pool; now and then a fresh key that will miss.
    function automatic lkv_pkg::t_data pick_key();
        if ($urandom_range(0, 9) == 0 || key_pool.size() == 0) begin
            return lkv_pkg::t_data'($urandom());
        end
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    // Pool somewhat larger than the capacity, so hits and evictions both occur.
    function automatic void build_pool(logic [lkv_pkg::CAP_W-1:0] cap);
        int held;
        int pool_size;
        held = (cap == 0) ? 1 : ((int'(cap) > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : int'(cap));
        pool_size = $urandom_range(held + 1, 2 * held + 4);
        key_pool.delete();
        repeat (pool_size) begin
            if ($urandom_range(0, 5) == 0) begin
                key_pool.push_back(extreme_word());
            end else begin
                key_pool.push_back(lkv_pkg::t_data'($urandom()));
            end
        end
    endfunction

    // Present one command; start stays high when the next follows at once.
    task automatic issue_op(lkv_pkg::t_op op, lkv_pkg::t_data key, lkv_pkg::t_data val);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_lookup_key  <= key;
        i_write_value <= val;
        do @(posedge i_clk); while (busy);
    endtask

    // Let every result come back before the capacity changes.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
        int gap;
        drain();
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        repeat (gap) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = lkv_pkg::OP_GET;
        i_lookup_key  = '0;
        i_write_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        gaps_on       = 1'b1;
        phase_cap     = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16,
                          5'd3, 5'd8, 5'd2, 5'd15, 5'd16, 5'd16};
        phase_cap[10] = 5'($urandom_range(0, 31));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: miss on an empty store, extreme keys and values, updates.
        issue_op(lkv_pkg::OP_GET, '0, pick_value());
        issue_op(lkv_pkg::OP_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
        issue_op(lkv_pkg::OP_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
        issue_op(lkv_pkg::OP_PUT, '0, '0);
        issue_op(lkv_pkg::OP_PUT, -32'sd1, -32'sd1);
        issue_op(lkv_pkg::OP_GET, 32'sh8000_0000, pick_value());
        issue_op(lkv_pkg::OP_GET, 32'sh7fff_ffff, pick_value());
        issue_op(lkv_pkg::OP_PUT, 32'sh7fff_ffff, 32'sh1234_5678);
        issue_op(lkv_pkg::OP_GET, 32'sh7fff_ffff, pick_value());
        issue_op(lkv_pkg::OP_GET, -32'sd1, pick_value());
        issue_op(lkv_pkg::OP_GET, 32'sd1, pick_value());

        // Directed: capacity lowered below the fill, so each new key evicts.
        write_capacity(5'd1);
        issue_op(lkv_pkg::OP_PUT, 32'sd5, 32'sd55);
        issue_op(lkv_pkg::OP_PUT, 32'sd6, 32'sd66);
        issue_op(lkv_pkg::OP_GET, 32'sd5, pick_value());
        issue_op(lkv_pkg::OP_GET, 32'sd6, pick_value());
        issue_op(lkv_pkg::OP_PUT, 32'sd6, -32'sd66);
        issue_op(lkv_pkg::OP_GET, 32'sd6, pick_value());
        issue_op(lkv_pkg::OP_GET, 32'sh8000_0000, pick_value());

        // Random phases, each with its own capacity and key pool.
        for (int p = 0; p < PHASES; p++) begin
            gaps_on = (p % 3) != 2;
            write_capacity(phase_cap[p]);
            build_pool(phase_cap[p]);
            repeat (PHASE_OPS) begin
                issue_op(($urandom_range(0, 1) == 1) ? lkv_pkg::OP_PUT : lkv_pkg::OP_GET,
                         pick_key(), pick_value());
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/lkv_pkg.sv
hdl/lkv_lookup.sv
hdl/lkv_entry_array.sv
hdl/lru_key_value_cache_core.sv
hdl/lkv_checker.sv
verif/lru_key_value_cache_core_checker.sv
verif/lru_key_value_cache_core_tb.sv
